// ===== rtl/ubbu_pkg.sv =====
package ubbu_pkg;

    localparam int unsigned CP_W = 21;

    // Codepoint bounds of the reverse byte table.
    localparam logic [CP_W-1:0] CP_SHIFT_LO  = 21'd256;
    localparam logic [CP_W-1:0] CP_SHIFT_HI  = 21'd288;
    localparam logic [CP_W-1:0] CP_HIGH_LO   = 21'd289;
    localparam logic [CP_W-1:0] CP_HIGH_HI   = 21'd322;
    localparam logic [CP_W-1:0] CP_SOFT_HYPH = 21'd323;
    localparam logic [7:0]      HIGH_OFFSET  = 8'd162;
    localparam logic [7:0]      SOFT_HYPH_B  = 8'd173;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_error;
    } t_out;

    typedef struct packed {
        logic [1:0]      pending;
        logic [CP_W-1:0] acc;
        logic            discarding;
    } t_state;

endpackage

// ===== rtl/ubbu_decode.sv =====
module ubbu_decode (
    input  ubbu_pkg::t_state i_state,
    input  ubbu_pkg::t_in    i_in,
    output ubbu_pkg::t_state o_state,
    output logic             o_res_valid,
    output ubbu_pkg::t_out   o_res
);

    logic [ubbu_pkg::CP_W-1:0] acc_sh;
    logic [ubbu_pkg::CP_W-1:0] cp;
    logic                      map_ok;
    logic [7:0]                map_byte;
    logic [7:0]                b;
    logic                      last;

    assign b      = i_in.in_byte;
    assign last   = i_in.in_last;
    assign acc_sh = {i_state.acc[ubbu_pkg::CP_W-7:0], b[5:0]};
    assign cp     = (i_state.pending != 2'd0) ? acc_sh
                                              : {{(ubbu_pkg::CP_W-8){1'b0}}, b};

    always_comb begin
        map_ok   = 1'b1;
        map_byte = cp[7:0];
        if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
            (cp >= 21'd174 && cp <= 21'd255)) begin
            map_byte = cp[7:0];
        end else if (cp >= ubbu_pkg::CP_SHIFT_LO && cp <= ubbu_pkg::CP_SHIFT_HI) begin
            map_byte = cp[7:0];
        end else if (cp >= ubbu_pkg::CP_HIGH_LO && cp <= ubbu_pkg::CP_HIGH_HI) begin
            map_byte = cp[7:0] - ubbu_pkg::HIGH_OFFSET;
        end else if (cp == ubbu_pkg::CP_SOFT_HYPH) begin
            map_byte = ubbu_pkg::SOFT_HYPH_B;
        end else begin
            map_ok = 1'b0;
        end
    end

    always_comb begin
        logic finish;
        logic error;
        finish      = 1'b0;
        error       = 1'b0;
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_state.discarding) begin
            if (last) begin
                o_state.discarding = 1'b0;
            end
        end else if (i_state.pending != 2'd0) begin
            o_state.acc     = acc_sh;
            o_state.pending = i_state.pending - 2'd1;
            if (i_state.pending == 2'd1) begin
                finish = 1'b1;
            end else if (last) begin
                error = 1'b1;
            end
        end else if (!b[7]) begin
            finish = 1'b1;
        end else if (b[7:5] == 3'b110) begin
            o_state.acc     = {{(ubbu_pkg::CP_W-5){1'b0}}, b[4:0]};
            o_state.pending = 2'd1;
            error           = last;
        end else if (b[7:4] == 4'b1110) begin
            o_state.acc     = {{(ubbu_pkg::CP_W-4){1'b0}}, b[3:0]};
            o_state.pending = 2'd2;
            error           = last;
        end else if (b[7:3] == 5'b11110) begin
            o_state.acc     = {{(ubbu_pkg::CP_W-3){1'b0}}, b[2:0]};
            o_state.pending = 2'd3;
            error           = last;
        end else begin
            error = 1'b1;
        end

        if (finish) begin
            o_state.pending = 2'd0;
            o_state.acc     = '0;
            if (map_ok) begin
                o_res_valid    = 1'b1;
                o_res.out_byte = map_byte;
                o_res.out_last = last;
            end else begin
                error = 1'b1;
            end
        end

        // A rejected token is skipped up to its last byte, unless this was it.
        if (error) begin
            o_state.pending    = 2'd0;
            o_state.acc        = '0;
            o_state.discarding = !last;
            o_res_valid        = 1'b1;
            o_res.out_byte     = 8'd0;
            o_res.out_last     = 1'b1;
            o_res.out_error    = 1'b1;
        end
    end

endmodule

// ===== rtl/utf8_byte_level_bpe_unmap.sv =====
// Decodes the UTF-8 bytes of one token string and maps each codepoint back
// through the reverse byte-to-unicode table to one raw byte. One byte is taken
// every cycle while the input is not stalled; a result is registered into the
// output register. Behind the output register sits a one-beat skid register, so
// the input is stalled only when both hold a beat the consumer has not taken.
// A format error gives one beat with out_error and out_last set, and the rest
// of that token's bytes are consumed without results.
module utf8_byte_level_bpe_unmap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ubbu_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ubbu_pkg::t_out o_out
);

    ubbu_pkg::t_state r_state;
    ubbu_pkg::t_state n_state;
    ubbu_pkg::t_out   r_out;
    ubbu_pkg::t_out   r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    ubbu_pkg::t_out   res;
    logic             res_valid;
    logic             in_acc;
    logic             out_acc;

    ubbu_decode u_decode (
        .i_state     (r_state),
        .i_in        (i_in),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc && res_valid;
            end
        end else if (in_acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_acc) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_acc && res_valid) begin
            r_skid <= res;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_error) |-> (o_out.out_last && o_out.out_byte == 8'd0))
        else $error("error beat without last flag or with a nonzero byte");

    a_discard_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.discarding |-> (r_state.pending == 2'd0 && r_state.acc == '0))
        else $error("discarding while a sequence is still pending");

    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.discarding) |-> !res_valid)
        else $error("result produced while discarding a rejected token");

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CP_W         = ubbu_pkg::CP_W;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_BYTES = 780;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_AT     = 500;
    localparam int QUIET_TAIL   = 80;
    localparam int TAIL_CYCLES  = 8;

    // Directed tokens, written as {last, byte}.
    localparam logic [8:0] DIRECTED [29] = '{
        9'h141,                         // plain ASCII
        9'h100, 9'h17F,                 // single bytes outside the table
        9'h0C4, 9'h180,                 // 256 maps to byte 0
        9'h0C5, 9'h183,                 // 323 maps to the soft hyphen
        9'h0C4, 9'h0A1, 9'h0C5, 9'h182, // 289 and 322, edges of the high range
        9'h0E0, 9'h080, 9'h1A1,         // overlong three-byte form
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF, // largest codepoint, unmapped
        9'h0C4, 9'h100,                 // continuation tag is not checked
        9'h080, 9'h041, 9'h1FF,         // bad lead, then the token is skipped
        9'h1FF,                         // bad lead on the final byte
        9'h1E5,                         // lead byte cut off by the last flag
        9'h0F0, 9'h190,                 // four-byte form cut short
        9'h0C3, 9'h1BF                  // 255 maps to itself
    };

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    ubbu_pkg::t_in  in_beat   = '0;
    logic           out_stall = 1'b0;
    logic           in_stall;
    logic           out_valid;
    ubbu_pkg::t_out out_res;

    utf8_byte_level_bpe_unmap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    ubbu_pkg::t_in  token_bytes_q [$];
    ubbu_pkg::t_out raw_byte_q [$];
    ubbu_pkg::t_out want_res;

    // Decoder state as the bench sees it.
    logic [1:0]      dec_pend = '0;
    logic [CP_W-1:0] dec_acc  = '0;
    logic            dec_skip = 1'b0;

    int   cycle      = 0;
    int   n_sent     = 0;
    int   n_total    = 0;
    int   n_tokens   = 0;
    int   n_results  = 0;
    int   n_errors   = 0;
    int   n_mismatch = 0;
    int   gap_left   = 0;
    int   hold_left  = 0;
    bit   drained    = 1'b0;
    bit   held_long  = 1'b0;
    logic quiet      = 1'b0;
    logic calm;

    // Random idling stops whenever cycle bits 8:7 are both set, and in the tail.
    assign calm = quiet || (cycle[8:7] == 2'b11);

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 20) begin
            $display("mismatch at cycle %0d: %s", cycle, msg);
        end
    endtask

    function automatic ubbu_pkg::t_out reject_token(input logic last);
        ubbu_pkg::t_out res;
        dec_pend = '0;
        dec_acc  = '0;
        dec_skip = !last;
        res.out_byte  = 8'd0;
        res.out_last  = 1'b1;
        res.out_error = 1'b1;
        return res;
    endfunction

    function automatic ubbu_pkg::t_out finish_codepoint(input logic [CP_W-1:0] cp,
                                                        input logic last);
        ubbu_pkg::t_out res;
        logic           ok;
        logic [7:0]     raw;
        ok  = 1'b1;
        raw = 8'd0;
        dec_pend = '0;
        dec_acc  = '0;
        if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) || (cp >= 174 && cp <= 255)) begin
            raw = cp[7:0];
        end else if (cp >= ubbu_pkg::CP_SHIFT_LO && cp <= ubbu_pkg::CP_SHIFT_HI) begin
            raw = 8'(cp - ubbu_pkg::CP_SHIFT_LO);
        end else if (cp >= ubbu_pkg::CP_HIGH_LO && cp <= ubbu_pkg::CP_HIGH_HI) begin
            raw = 8'(cp - ubbu_pkg::CP_HIGH_LO + 127);
        end else if (cp == ubbu_pkg::CP_SOFT_HYPH) begin
            raw = ubbu_pkg::SOFT_HYPH_B;
        end else begin
            ok = 1'b0;
        end
        if (!ok) begin
            return reject_token(last);
        end
        res.out_byte  = raw;
        res.out_last  = last;
        res.out_error = 1'b0;
        return res;
    endfunction

    function automatic void decode_step(input ubbu_pkg::t_in beat);
        ubbu_pkg::t_out res;
        logic           emit;
        logic [7:0]     b;
        b    = beat.in_byte;
        emit = 1'b0;
        res  = '0;
        if (dec_skip) begin
            if (beat.in_last) begin
                dec_skip = 1'b0;
            end
        end else if (dec_pend != 2'd0) begin
            dec_acc  = {dec_acc[CP_W-7:0], b[5:0]};
            dec_pend = dec_pend - 2'd1;
            if (dec_pend == 2'd0) begin
                emit = 1'b1;
                res  = finish_codepoint(dec_acc, beat.in_last);
            end else if (beat.in_last) begin
                emit = 1'b1;
                res  = reject_token(1'b1);
            end
        end else if (!b[7]) begin
            emit = 1'b1;
            res  = finish_codepoint(CP_W'(b), beat.in_last);
        end else begin
            if (b[7:5] == 3'b110) begin
                dec_acc  = CP_W'(b[4:0]);
                dec_pend = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_acc  = CP_W'(b[3:0]);
                dec_pend = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                dec_acc  = CP_W'(b[2:0]);
                dec_pend = 2'd3;
            end
            // A bad lead leaves nothing pending; a good lead cannot end a token.
            if (dec_pend == 2'd0 || beat.in_last) begin
                emit = 1'b1;
                res  = reject_token(beat.in_last);
            end
        end
        if (emit) begin
            raw_byte_q.push_back(res);
        end
    endfunction

    function automatic logic [CP_W-1:0] codepoint_of_raw(input logic [7:0] r);
        if (r <= 8'd32) begin
            return ubbu_pkg::CP_SHIFT_LO + CP_W'(r);
        end else if (r >= 8'd127 && r <= 8'd160) begin
            return ubbu_pkg::CP_HIGH_LO + CP_W'(r - 8'd127);
        end else if (r == ubbu_pkg::SOFT_HYPH_B) begin
            return ubbu_pkg::CP_SOFT_HYPH;
        end
        return CP_W'(r);
    endfunction

    function automatic logic [CP_W-1:0] unmapped_codepoint();
        case ($urandom_range(0, 3))
            0: return CP_W'($urandom_range(0, 32));
            1: return CP_W'($urandom_range(127, 160));
            2: return CP_W'(173);
            default: return CP_W'($urandom_range(324, 21'h1FFFFF));
        endcase
    endfunction

    function automatic int utf8_min_len(input logic [CP_W-1:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic last);
        ubbu_pkg::t_in beat;
        beat.in_byte = b;
        beat.in_last = last;
        token_bytes_q.push_back(beat);
        if (last) begin
            n_tokens++;
        end
    endtask

    // Sends the first keep bytes of a nb-byte encoding of cp.
    task automatic push_codepoint(input logic [CP_W-1:0] cp, input int nb, input int keep,
                                  input bit fin);
        logic [7:0] enc [4];
        logic [1:0] tag;
        int         k;
        case (nb)
            1: enc[0] = {1'b0, cp[6:0]};
            2: enc[0] = {3'b110, cp[10:6]};
            3: enc[0] = {4'b1110, cp[15:12]};
            default: enc[0] = {5'b11110, cp[20:18]};
        endcase
        for (k = 1; k < nb; k++) begin
            tag = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b10;
            enc[k] = {tag, cp[6*(nb-1-k) +: 6]};
        end
        for (k = 0; k < keep; k++) begin
            push_beat(enc[k], fin && (k == keep - 1));
        end
    endtask

    task automatic push_any_form(input logic [CP_W-1:0] cp, input bit fin);
        int nb;
        nb = $urandom_range(utf8_min_len(cp), 4);
        push_codepoint(cp, nb, nb, fin);
    endtask

    task automatic push_random_token();
        int kind;
        int ncp;
        int bad_at;
        int nb;
        int i;
        kind = $urandom_range(0, 9);
        ncp  = $urandom_range(1, 5);
        if (kind <= 6) begin
            for (i = 0; i < ncp; i++) begin
                push_any_form(codepoint_of_raw(8'($urandom)), i == ncp - 1);
            end
        end else if (kind == 7) begin
            bad_at = $urandom_range(0, ncp - 1);
            for (i = 0; i < ncp; i++) begin
                push_any_form((i == bad_at) ? unmapped_codepoint()
                                            : codepoint_of_raw(8'($urandom)), i == ncp - 1);
            end
        end else if (kind == 8) begin
            for (i = 0; i < ncp - 1; i++) begin
                push_any_form(codepoint_of_raw(8'($urandom)), 1'b0);
            end
            nb = $urandom_range(2, 4);
            push_codepoint(CP_W'($urandom), nb, $urandom_range(1, nb - 1), 1'b1);
        end else begin
            for (i = 0; i < ncp; i++) begin
                push_beat(8'($urandom), i == ncp - 1);
            end
        end
    endtask

    initial begin
        foreach (DIRECTED[i]) begin
            push_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
        end
        while (token_bytes_q.size() < RANDOM_BYTES) begin
            push_random_token();
        end
        n_total = token_bytes_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (token_bytes_q.size() != 0 || in_valid || raw_byte_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d tokens, checked %0d results of which %0d were errors",
                 n_sent, n_tokens, n_results, n_errors);
        if (n_mismatch == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Sender: holds a stalled beat, otherwise idles in short bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_step(in_beat);
                n_sent++;
                if (!calm && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(1, 4);
                end
            end
            quiet <= (n_sent + QUIET_TAIL >= n_total);
            if (in_valid && in_stall) begin
                // The beat on the bus stays put until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (n_sent == DRAIN_AT && !drained) begin
                in_valid <= 1'b0;
                if (raw_byte_q.size() == 0) begin
                    drained = 1'b1;
                end
            end else if (token_bytes_q.size() != 0) begin
                in_valid <= 1'b1;
                in_beat  <= token_bytes_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every beat taken and stalls in bursts, once for a long time.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (out_res.out_error) begin
                    n_errors++;
                end
                if (raw_byte_q.size() == 0) begin
                    report_mismatch($sformatf("result byte=%02h last=%0b error=%0b not expected",
                                              out_res.out_byte, out_res.out_last,
                                              out_res.out_error));
                end else begin
                    want_res = raw_byte_q.pop_front();
                    if (out_res.out_byte !== want_res.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_res.out_byte, want_res.out_byte));
                    end
                    if (out_res.out_last !== want_res.out_last) begin
                        report_mismatch($sformatf("out_last %0b, expected %0b",
                                                  out_res.out_last, want_res.out_last));
                    end
                    if (out_res.out_error !== want_res.out_error) begin
                        report_mismatch($sformatf("out_error %0b, expected %0b",
                                                  out_res.out_error, want_res.out_error));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!held_long && cycle >= LONG_HOLD_AT) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle, raw_byte_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/ubbu_pkg.sv
rtl/ubbu_decode.sv
rtl/utf8_byte_level_bpe_unmap.sv
bench/tb.sv
